[hdl/sdc_pkg.sv]
package sdc_pkg;

	localparam int MAG_W      = 16;
	localparam int FRAC_W     = 16;
	localparam int N_W        = FRAC_W + 1;   // 0.16 fraction plus one bit so 1.0 is exact
	localparam int CH_W       = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_COLORMAP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_DB   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_DB   = 2'd2;

	localparam logic signed [MAG_W-1:0] MIN_DB_RST = -16'sd30720;
	localparam logic signed [MAG_W-1:0] MAX_DB_RST = 16'sd0;

	localparam logic [FRAC_W-1:0] DB_ONE = 16'd256;      // 1 dB in q8.8
	localparam logic [N_W-1:0]    N_ONE  = 17'h10000;

	typedef enum logic [1:0] {
		CMAP_INFERNO = 2'd0,
		CMAP_VIRIDIS = 2'd1,
		CMAP_PLASMA  = 2'd2,
		CMAP_JET     = 2'd3
	} cmap_t;

endpackage

[hdl/sdc_mag_if.sv]
interface sdc_mag_if;
	import sdc_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [MAG_W-1:0] magnitude_db;

	modport source (output valid, output magnitude_db, input ready);
	modport sink (input valid, input magnitude_db, output ready);

endinterface

[hdl/sdc_rgb_if.sv]
interface sdc_rgb_if;
	import sdc_pkg::*;

	logic            valid;
	logic            ready;
	logic [CH_W-1:0] red;
	logic [CH_W-1:0] green;
	logic [CH_W-1:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink (input valid, input red, input green, input blue, output ready);

endinterface

[hdl/sdc_norm.sv]
module sdc_norm (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic signed [sdc_pkg::MAG_W-1:0] magnitude_db,
	input  logic signed [sdc_pkg::MAG_W-1:0] min_db,
	input  logic [sdc_pkg::FRAC_W-1:0]       divisor,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [sdc_pkg::N_W-1:0]          n
);
	import sdc_pkg::*;

	localparam int STEPS = FRAC_W;

	logic [MAG_W:0]    diff;
	logic              below;
	logic              above;

	logic              v_s1;
	logic              below_s1;
	logic              above_s1;
	logic [FRAC_W-1:0] rem_s1;
	logic              adv_s1;

	logic              div_v_s     [STEPS];
	logic              div_below_s [STEPS];
	logic              div_above_s [STEPS];
	logic [FRAC_W-1:0] div_rem_s   [STEPS];
	logic [FRAC_W-1:0] div_quo_s   [STEPS];
	logic              adv         [STEPS+1];

	assign diff  = {magnitude_db[MAG_W-1], magnitude_db} - {min_db[MAG_W-1], min_db};
	assign below = diff[MAG_W] || (diff == '0);
	assign above = !below && (diff[FRAC_W-1:0] >= divisor);

	assign adv_s1   = !v_s1 || adv[0];
	assign in_ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			below_s1 <= below;
			above_s1 <= above;
			rem_s1   <= (below || above) ? '0 : diff[FRAC_W-1:0];
		end
	end

	// restoring divide, one quotient bit per stage
	assign adv[STEPS] = out_ready;

	for (genvar k = 0; k < STEPS; k++) begin : g_div
		logic              src_v;
		logic              src_below;
		logic              src_above;
		logic [FRAC_W-1:0] src_rem;
		logic [FRAC_W-1:0] src_quo;
		logic [FRAC_W:0]   dbl;
		logic              ge;

		if (k == 0) begin : g_first
			assign src_v     = v_s1;
			assign src_below = below_s1;
			assign src_above = above_s1;
			assign src_rem   = rem_s1;
			assign src_quo   = '0;
		end else begin : g_next
			assign src_v     = div_v_s[k-1];
			assign src_below = div_below_s[k-1];
			assign src_above = div_above_s[k-1];
			assign src_rem   = div_rem_s[k-1];
			assign src_quo   = div_quo_s[k-1];
		end

		assign dbl    = {src_rem, 1'b0};
		assign ge     = dbl >= {1'b0, divisor};
		assign adv[k] = !div_v_s[k] || adv[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_v_s[k] <= 1'b0;
			end else if (adv[k]) begin
				div_v_s[k] <= src_v;
			end
		end

		always_ff @(posedge clk) begin
			if (adv[k] && src_v) begin
				div_below_s[k] <= src_below;
				div_above_s[k] <= src_above;
				div_rem_s[k]   <= ge ? FRAC_W'(dbl - {1'b0, divisor}) : dbl[FRAC_W-1:0];
				div_quo_s[k]   <= {src_quo[FRAC_W-2:0], ge};
			end
		end
	end

	assign out_valid = div_v_s[STEPS-1];
	assign n = div_below_s[STEPS-1] ? '0 :
		div_above_s[STEPS-1] ? N_ONE : {1'b0, div_quo_s[STEPS-1]};

	a_s1_capture: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> v_s1)
		else $error("accepted transaction did not reach the first stage");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		div_v_s[STEPS-1] && !div_below_s[STEPS-1] && !div_above_s[STEPS-1]
		|-> div_rem_s[STEPS-1] < divisor)
		else $error("divide remainder not below divisor");

endmodule

[hdl/sdc_cmap.sv]
module sdc_cmap (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [sdc_pkg::N_W-1:0]   n,
	input  sdc_pkg::cmap_t            sel,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [sdc_pkg::CH_W-1:0]  red,
	output logic [sdc_pkg::CH_W-1:0]  green,
	output logic [sdc_pkg::CH_W-1:0]  blue
);
	import sdc_pkg::*;

	localparam int K_W   = 18;                 // 255 * slope, or 1 - n for plasma blue
	localparam int P_W   = K_W + N_W;
	localparam int Y_W   = 18;                 // 255 * channel in thousandths
	localparam int SEG_W = 14;                 // quarter of the unit range
	localparam int M_W   = 19;
	localparam int M_SH  = 28;
	localparam int Z_W   = Y_W + M_W;
	localparam int Q_W   = 48;
	localparam int RGB_W = 3 * CH_W;

	localparam logic [K_W-1:0] K_VIR_R = 18'd83895;
	localparam logic [K_W-1:0] K_VIR_G = 18'd224910;
	localparam logic [K_W-1:0] K_VIR_B = 18'd86445;
	localparam logic [K_W-1:0] K_PLA_R = 18'd228735;
	localparam logic [K_W-1:0] K_PLA_G = 18'd176970;
	localparam logic [Y_W-1:0] B_VIR_R = 18'd68085;
	localparam logic [Y_W-1:0] B_VIR_G = 18'd1020;
	localparam logic [Y_W-1:0] B_VIR_B = 18'd83895;
	localparam logic [Y_W-1:0] B_PLA_R = 18'd12750;
	localparam logic [Y_W-1:0] B_PLA_B = 18'd134640;
	localparam logic [17:0]    K_PLA_Q = 18'd120360;
	localparam logic [M_W-1:0] DIV1000_M = 19'd268436;   // ceil(2^28 / 1000)
	localparam logic [N_W+1:0] JET_PEAK  = 19'd98304;    // 1.5 in 0.16
	localparam logic [SEG_W-1:0] SEG_MASK = 14'h3fff;
	localparam logic [N_W-1:0] JET_C_R = 17'd49152;
	localparam logic [N_W-1:0] JET_C_G = 17'd32768;
	localparam logic [N_W-1:0] JET_C_B = 17'd16384;

	function automatic logic [CH_W-1:0] seg_frac(input logic [CH_W-1:0] k,
			input logic [SEG_W:0] t, input logic up);
		logic [SEG_W+CH_W:0] p;
		p = (SEG_W+CH_W+1)'(k) * (SEG_W+CH_W+1)'(t) +
			(up ? (SEG_W+CH_W+1)'(SEG_MASK) : '0);
		return p[SEG_W+CH_W-1:SEG_W];
	endfunction

	function automatic logic [CH_W-1:0] jet_chan(input logic [N_W-1:0] x,
			input logic [N_W-1:0] c);
		logic [N_W-1:0]      d;
		logic [N_W+1:0]      d4;
		logic [N_W:0]        v;
		logic [N_W+CH_W:0]   sc;
		d  = (x > c) ? x - c : c - x;
		d4 = {d, 2'b00};
		v  = (d4 >= JET_PEAK) ? '0 : (N_W+1)'(JET_PEAK - d4);
		if (v > (N_W+1)'(N_ONE)) begin
			v = (N_W+1)'(N_ONE);
		end
		sc = {v, {CH_W{1'b0}}} - (N_W+CH_W+1)'(v);
		return sc[FRAC_W+CH_W-1:FRAC_W];
	endfunction

	// stage 1: slope products and the direct colormaps
	logic [K_W-1:0]    kr, kg, kb;
	logic [P_W-1:0]    pr_c, pg_c, pb_c;
	logic [1:0]        seg;
	logic [SEG_W:0]    t;
	logic [CH_W-1:0]   inf_r, inf_g, inf_b;
	logic [RGB_W-1:0]  dir_c;

	logic              v_s1, v_s2, v_s3, v_s4, v_s5;
	logic              adv_s1, adv_s2, adv_s3, adv_s4, adv_s5;
	cmap_t             sel_s1, sel_s2, sel_s3, sel_s4, sel_s5;
	logic [P_W-1:0]    pr_s1, pg_s1, pb_s1;
	logic [RGB_W-1:0]  dir_s1, dir_s2, dir_s3, dir_s4;
	logic [Y_W-1:0]    yr_s2, yg_s2, yb_s2;
	logic [FRAC_W-1:0] pq_s2;
	logic [Y_W-1:0]    yr_s3, yg_s3, yb_s3;
	logic [CH_W-1:0]   zr_s4, zg_s4, zb_s4;
	logic [CH_W-1:0]   red_s5, green_s5, blue_s5;

	logic [Y_W-1:0]    br, bg, bb;
	logic [Q_W-1:0]    pq_c;
	logic [Z_W-1:0]    zr_c, zg_c, zb_c;

	assign adv_s5   = !v_s5 || out_ready;
	assign adv_s4   = !v_s4 || adv_s5;
	assign adv_s3   = !v_s3 || adv_s4;
	assign adv_s2   = !v_s2 || adv_s3;
	assign adv_s1   = !v_s1 || adv_s2;
	assign in_ready = adv_s1;

	always_comb begin
		kr = '0;
		kg = '0;
		kb = '0;
		unique case (sel)
			CMAP_VIRIDIS: begin
				kr = K_VIR_R;
				kg = K_VIR_G;
				kb = K_VIR_B;
			end
			CMAP_PLASMA: begin
				kr = K_PLA_R;
				kg = K_PLA_G;
				kb = K_W'(N_ONE) - K_W'(n);    // blue takes n * (1 - n)
			end
			CMAP_INFERNO, CMAP_JET: begin
			end
		endcase
	end

	assign pr_c = P_W'(kr) * P_W'(n);
	assign pg_c = P_W'(kg) * P_W'(n);
	assign pb_c = P_W'(kb) * P_W'(n);

	assign seg = n[N_W-1] ? 2'd3 : n[FRAC_W-1:SEG_W];
	assign t   = n[N_W-1] ? {1'b1, {SEG_W{1'b0}}} : {1'b0, n[SEG_W-1:0]};

	always_comb begin
		unique case (seg)
			2'd0: begin
				inf_r = seg_frac(8'd80, t, 1'b0);
				inf_g = '0;
				inf_b = 8'd40 + seg_frac(8'd100, t, 1'b0);
			end
			2'd1: begin
				inf_r = 8'd80 + seg_frac(8'd175, t, 1'b0);
				inf_g = seg_frac(8'd30, t, 1'b0);
				inf_b = 8'd140 - seg_frac(8'd60, t, 1'b1);
			end
			2'd2: begin
				inf_r = 8'd255;
				inf_g = 8'd30 + seg_frac(8'd170, t, 1'b0);
				inf_b = 8'd80 - seg_frac(8'd80, t, 1'b1);
			end
			2'd3: begin
				inf_r = 8'd255;
				inf_g = 8'd200 + seg_frac(8'd55, t, 1'b0);
				inf_b = seg_frac(8'd180, t, 1'b0);
			end
		endcase
	end

	assign dir_c = (sel == CMAP_JET) ?
		{jet_chan(n, JET_C_R), jet_chan(n, JET_C_G), jet_chan(n, JET_C_B)} :
		{inf_r, inf_g, inf_b};

	// stage 2: add intercepts, second product for plasma blue
	always_comb begin
		br = '0;
		bg = '0;
		bb = '0;
		unique case (sel_s1)
			CMAP_VIRIDIS: begin
				br = B_VIR_R;
				bg = B_VIR_G;
				bb = B_VIR_B;
			end
			CMAP_PLASMA: begin
				br = B_PLA_R;
			end
			CMAP_INFERNO, CMAP_JET: begin
			end
		endcase
	end

	assign pq_c = Q_W'(K_PLA_Q) * Q_W'(pb_s1[2*FRAC_W-2:0]);

	// stage 4: divide by 1000 through the reciprocal
	assign zr_c = Z_W'(yr_s3) * Z_W'(DIV1000_M);
	assign zg_c = Z_W'(yg_s3) * Z_W'(DIV1000_M);
	assign zb_c = Z_W'(yb_s3) * Z_W'(DIV1000_M);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= in_valid;
			if (adv_s2) v_s2 <= v_s1;
			if (adv_s3) v_s3 <= v_s2;
			if (adv_s4) v_s4 <= v_s3;
			if (adv_s5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			sel_s1 <= sel;
			pr_s1  <= pr_c;
			pg_s1  <= pg_c;
			pb_s1  <= pb_c;
			dir_s1 <= dir_c;
		end
		if (adv_s2 && v_s1) begin
			sel_s2 <= sel_s1;
			yr_s2  <= br + Y_W'(pr_s1[P_W-1:FRAC_W]);
			yg_s2  <= bg + Y_W'(pg_s1[P_W-1:FRAC_W]);
			yb_s2  <= bb + Y_W'(pb_s1[P_W-1:FRAC_W]);
			pq_s2  <= pq_c[Q_W-1:2*FRAC_W];
			dir_s2 <= dir_s1;
		end
		if (adv_s3 && v_s2) begin
			sel_s3 <= sel_s2;
			yr_s3  <= yr_s2;
			yg_s3  <= yg_s2;
			yb_s3  <= (sel_s2 == CMAP_PLASMA) ? B_PLA_B + Y_W'(pq_s2) : yb_s2;
			dir_s3 <= dir_s2;
		end
		if (adv_s4 && v_s3) begin
			sel_s4 <= sel_s3;
			zr_s4  <= zr_c[M_SH+CH_W-1:M_SH];
			zg_s4  <= zg_c[M_SH+CH_W-1:M_SH];
			zb_s4  <= zb_c[M_SH+CH_W-1:M_SH];
			dir_s4 <= dir_s3;
		end
		if (adv_s5 && v_s4) begin
			sel_s5 <= sel_s4;
			if (sel_s4 == CMAP_INFERNO || sel_s4 == CMAP_JET) begin
				{red_s5, green_s5, blue_s5} <= dir_s4;
			end else begin
				red_s5   <= zr_s4;
				green_s5 <= zg_s4;
				blue_s5  <= zb_s4;
			end
		end
	end

	assign out_valid = v_s5;
	assign red       = red_s5;
	assign green     = green_s5;
	assign blue      = blue_s5;

	a_inferno_order: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && sel_s5 == CMAP_INFERNO && green_s5 != '0 |-> red_s5 >= 8'd80)
		else $error("inferno green rose before red left the first segment");

	a_viridis_green: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && sel_s5 == CMAP_VIRIDIS |-> green_s5 != '0)
		else $error("viridis green below its floor");

endmodule

[hdl/spectrogram_db_colorizer_core.sv]
// channel  dir  handshake           payload
// bin      in   valid / ready       magnitude_db  (signed q8.8 dB)
// pixel    out  valid / ready       red, green, blue  (8 bit each)
// cfg      in   cfg_we, no wait     cfg_index, cfg_data
//
// one bin accepted per cycle while pixel does not stall; the path is an input stage,
// sixteen one-bit divide stages for the normalisation and five colour map stages
// reset clears every stage valid bit and loads inferno, -120 dB and 0 dB
// a stalled pixel holds the last stage; earlier stages keep filling bubbles,
// so bin.ready drops only once every stage holds a transaction
module spectrogram_db_colorizer_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [sdc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sdc_pkg::CFG_DATA_W-1:0]    cfg_data,
	sdc_mag_if.sink                           bin,
	sdc_rgb_if.source                         pixel
);
	import sdc_pkg::*;

	cmap_t                   colormap_q;
	logic signed [MAG_W-1:0] min_db_q;
	logic signed [MAG_W-1:0] max_db_q;

	logic [MAG_W:0]          range_c;
	logic [FRAC_W-1:0]       divisor;

	logic                    nrm_valid;
	logic                    nrm_ready;
	logic [N_W-1:0]          nrm_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			colormap_q <= CMAP_INFERNO;
			min_db_q   <= MIN_DB_RST;
			max_db_q   <= MAX_DB_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_COLORMAP: colormap_q <= cmap_t'(cfg_data[1:0]);
				CFG_MIN_DB:   min_db_q   <= cfg_data[MAG_W-1:0];
				CFG_MAX_DB:   max_db_q   <= cfg_data[MAG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// empty or inverted range falls back to 1 dB
	assign range_c = {max_db_q[MAG_W-1], max_db_q} - {min_db_q[MAG_W-1], min_db_q};
	assign divisor = (range_c[MAG_W] || range_c == '0) ? DB_ONE : range_c[FRAC_W-1:0];

	sdc_norm u_norm (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (bin.valid),
		.in_ready     (bin.ready),
		.magnitude_db (bin.magnitude_db),
		.min_db       (min_db_q),
		.divisor      (divisor),
		.out_valid    (nrm_valid),
		.out_ready    (nrm_ready),
		.n            (nrm_n)
	);

	sdc_cmap u_cmap (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (nrm_valid),
		.in_ready  (nrm_ready),
		.n         (nrm_n),
		.sel       (colormap_q),
		.out_valid (pixel.valid),
		.out_ready (pixel.ready),
		.red       (pixel.red),
		.green     (pixel.green),
		.blue      (pixel.blue)
	);

endmodule
